### design/mfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfe_pkg: shared types and constants for the max flow engine
// Sequencer states, unit operation codes and register indexes.
// ----------------------------------------------------------------------------
package mfe_pkg;

    typedef enum logic [17:0] {
        S_CLEAR    = 18'h00001,
        S_IDLE     = 18'h00002,
        S_LD_RD1   = 18'h00004,
        S_LD_WR1   = 18'h00008,
        S_LD_RD2   = 18'h00010,
        S_LD_WR2   = 18'h00020,
        S_VIS_CLR  = 18'h00040,
        S_BFS_INIT = 18'h00080,
        S_POP      = 18'h00100,
        S_POP_W    = 18'h00200,
        S_BN_W     = 18'h00400,
        S_SC_RD    = 18'h00800,
        S_SC_CHK   = 18'h01000,
        S_AUG_PAR  = 18'h02000,
        S_AUG_PW   = 18'h04000,
        S_AUG_R1   = 18'h08000,
        S_AUG_R2   = 18'h10000,
        S_DONE     = 18'h20000
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD_SAT = 2'd0,
        OP_SUB     = 2'd1,
        OP_MIN     = 2'd2
    } alu_op_t;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    localparam logic [31:0] FLOW_MAX = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

### design/mfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/mfe_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfe_alu: shared capacity unit
// Saturating add, subtract and minimum on residual capacities.
// ----------------------------------------------------------------------------
module mfe_alu #(
    parameter int W    = 24,
    parameter int CAPW = 24
) (
    input  mfe_pkg::alu_op_t op,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] y
);
    import mfe_pkg::*;

    localparam logic [W:0] MASK = (W+1)'((65'd1 << CAPW) - 65'd1);

    logic [W:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        unique case (op)
            OP_ADD_SAT: y = (sum > MASK) ? MASK[W-1:0] : sum[W-1:0];
            OP_SUB:     y = a - b;
            OP_MIN:     y = (a < b) ? a : b;
            default:    y = a;
        endcase
    end
endmodule
`default_nettype wire

### design/max_flow_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_engine: Edmonds-Karp maximum flow engine
// Loads undirected edges into a residual matrix, then runs breadth-first
// searches and augments along shortest paths until none is left or the total saturates.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  edge in   start / busy       from_node, to_node, capacity, last_edge
//  result    done (1 cycle)     total_flow, flow_flag
//  config    cfg_we             cfg_index, cfg_wdata
//
//  An edge item does two read-modify-writes on the single matrix read port.
//  After the last item: each search first clears the visited marks (one
//  per node in use), seeds the queue, then reads each dequeued node and
//  scans its neighbours; each augmenting path is updated hop by hop.
//  After reset and after every result a clearing pass zeroes the matrix;
//  busy stays high throughout.
//  The result receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module max_flow_engine #(
    parameter int MAX_NODES = 128,
    parameter int CAP_WIDTH = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [6:0]  from_node,
    input  wire logic [6:0]  to_node,
    input  wire logic [15:0] capacity,
    input  wire logic        last_edge,
    output logic             done,
    output logic [31:0]      total_flow,
    output logic             flow_flag,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import mfe_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int OW    = (CAP_WIDTH > 16) ? CAP_WIDTH : 16;
    localparam int TW    = ((CAP_WIDTH > 32) ? CAP_WIDTH : 32) + 1;
    localparam logic [CAP_WIDTH-1:0] CAP_MASK = '1;

    // configuration
    logic [7:0] node_count_reg;
    logic [6:0] source_reg;
    logic [6:0] sink_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 8'd2;
            source_reg     <= 7'd0;
            sink_reg       <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_wdata;
                CFG_SOURCE:     source_reg     <= cfg_wdata[6:0];
                CFG_SINK:       sink_reg       <= cfg_wdata[6:0];
                default:        ;
            endcase
        end
    end

    // control and working registers
    state_t               state_reg, state_next;
    logic [NW-1:0]        a_reg, b_reg;
    logic [15:0]          cap_reg;
    logic                 last_reg;
    logic                 edge_ok_reg;
    logic [NW:0]          n_reg;
    logic [NW-1:0]        src_reg, dst_reg;
    logic [NW:0]          head_reg, tail_reg;
    logic [NW-1:0]        u_reg;
    logic [CAP_WIDTH-1:0] bu_reg;
    logic [NW:0]          v_reg;
    logic [CAP_WIDTH-1:0] push_reg;
    logic [NW-1:0]        cur_reg, p_reg;
    logic [31:0]          total_reg;
    logic                 flag_reg;
    logic [AW-1:0]        clr_reg;
    logic                 done_reg;
    logic [31:0]          total_flow_reg;
    logic                 flow_flag_reg;

    // memories
    logic                 m_we;
    logic [AW-1:0]        m_waddr, m_raddr;
    logic [CAP_WIDTH-1:0] m_wdata, m_rdata;
    logic                 par_we;
    logic [NW-1:0]        par_waddr, par_raddr, par_rdata;
    logic                 bn_we;
    logic [NW-1:0]        bn_waddr, bn_raddr;
    logic [CAP_WIDTH-1:0] bn_wdata, bn_rdata;
    logic                 q_we;
    logic [NW-1:0]        q_waddr, q_wdata, q_raddr, q_rdata;
    logic                 vis_we;
    logic [NW-1:0]        vis_waddr, vis_raddr;
    logic                 vis_wdata, vis_rdata;

    mfe_ram #(.WIDTH(CAP_WIDTH), .DEPTH(1 << AW)) u_matrix (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );
    mfe_ram #(.WIDTH(NW), .DEPTH(1 << NW)) u_parent (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(u_reg),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    mfe_ram #(.WIDTH(CAP_WIDTH), .DEPTH(1 << NW)) u_bneck (
        .clk(clk), .we(bn_we), .waddr(bn_waddr), .wdata(bn_wdata),
        .raddr(bn_raddr), .rdata(bn_rdata)
    );
    mfe_ram #(.WIDTH(NW), .DEPTH(1 << NW)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    // visited marks, cleared over the nodes in use before each search
    mfe_ram #(.WIDTH(1), .DEPTH(1 << NW)) u_visited (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    // shared capacity unit
    alu_op_t       alu_op;
    logic [OW-1:0] alu_a, alu_b, alu_y;

    mfe_alu #(.W(OW), .CAPW(CAP_WIDTH)) u_alu (
        .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y)
    );

    logic [NW-1:0] v_idx;
    logic          hit;
    logic [TW-1:0] tsum;
    logic [NW:0]   n_eff;

    assign v_idx = v_reg[NW-1:0];
    assign hit   = !vis_rdata && (m_rdata != '0);
    assign tsum  = TW'(total_reg) + TW'(push_reg);
    assign n_eff = (32'(node_count_reg) > MAX_NODES) ? (NW+1)'(MAX_NODES)
                                                     : (NW+1)'(node_count_reg);

    always_comb
    begin
        alu_op = OP_ADD_SAT;
        alu_a  = OW'(m_rdata);
        alu_b  = OW'(push_reg);
        unique case (1'b1)
            state_reg[$clog2(S_LD_WR1)], state_reg[$clog2(S_LD_WR2)]:
                alu_b = OW'(cap_reg);
            state_reg[$clog2(S_SC_CHK)]:
            begin
                alu_op = OP_MIN;
                alu_b  = OW'(bu_reg);
            end
            state_reg[$clog2(S_AUG_R1)]:
                alu_op = OP_SUB;
            default: ;
        endcase
    end

    // memory ports
    always_comb
    begin
        m_we      = 1'b0;
        m_waddr   = {a_reg, b_reg};
        m_wdata   = CAP_WIDTH'(alu_y);
        m_raddr   = {a_reg, b_reg};
        par_we    = 1'b0;
        par_waddr = v_idx;
        par_raddr = cur_reg;
        bn_we     = 1'b0;
        bn_waddr  = v_idx;
        bn_wdata  = CAP_WIDTH'(alu_y);
        bn_raddr  = q_rdata;
        q_we      = 1'b0;
        q_waddr   = tail_reg[NW-1:0];
        q_wdata   = v_idx;
        q_raddr   = head_reg[NW-1:0];
        vis_we    = 1'b0;
        vis_waddr = v_idx;
        vis_wdata = 1'b1;
        vis_raddr = v_idx;
        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = '0;
            end
            S_LD_WR1: m_we = 1'b1;
            S_LD_RD2: m_raddr = {b_reg, a_reg};
            S_LD_WR2:
            begin
                m_we    = edge_ok_reg;
                m_waddr = {b_reg, a_reg};
            end
            S_VIS_CLR:
            begin
                vis_we    = 1'b1;
                vis_wdata = 1'b0;
            end
            S_BFS_INIT:
            begin
                bn_we     = 1'b1;
                bn_waddr  = src_reg;
                bn_wdata  = CAP_MASK;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = src_reg;
                vis_we    = 1'b1;
                vis_waddr = src_reg;
            end
            S_SC_RD: m_raddr = {u_reg, v_idx};
            S_SC_CHK:
            begin
                par_we = hit;
                bn_we  = hit;
                q_we   = hit;
                vis_we = hit;
            end
            S_AUG_PW: m_raddr = {par_rdata, cur_reg};
            S_AUG_R1:
            begin
                m_we    = 1'b1;
                m_waddr = {p_reg, cur_reg};
                m_raddr = {cur_reg, p_reg};
            end
            S_AUG_R2:
            begin
                m_we    = 1'b1;
                m_waddr = {cur_reg, p_reg};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:     if (start) state_next = S_LD_RD1;
            S_LD_RD1:   state_next = edge_ok_reg ? S_LD_WR1 : S_LD_WR2;
            S_LD_WR1:   state_next = S_LD_RD2;
            S_LD_RD2:   state_next = S_LD_WR2;
            S_LD_WR2:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (src_reg == dst_reg || !(32'(src_reg) < 32'(n_reg))
                         || !(32'(dst_reg) < 32'(n_reg)) || !(32'(source_reg) < MAX_NODES)
                         || !(32'(sink_reg) < MAX_NODES) || source_reg == sink_reg)
                    state_next = S_DONE;
                else
                    state_next = S_VIS_CLR;
            end
            S_VIS_CLR:  state_next = (v_reg == n_reg - 1'b1) ? S_BFS_INIT : S_VIS_CLR;
            S_BFS_INIT: state_next = S_POP;
            S_POP:      state_next = (head_reg == tail_reg) ? S_DONE : S_POP_W;
            S_POP_W:    state_next = S_BN_W;
            S_BN_W:     state_next = S_SC_RD;
            S_SC_RD:    state_next = (v_reg == n_reg) ? S_POP : S_SC_CHK;
            S_SC_CHK:   state_next = (hit && v_idx == dst_reg) ? S_AUG_PAR : S_SC_RD;
            S_AUG_PAR:  state_next = S_AUG_PW;
            S_AUG_PW:   state_next = S_AUG_R1;
            S_AUG_R1:   state_next = S_AUG_R2;
            S_AUG_R2:
            begin
                if (p_reg != src_reg)
                    state_next = S_AUG_PAR;
                else if (tsum > TW'(FLOW_MAX))
                    state_next = S_DONE;
                else
                    state_next = S_VIS_CLR;
            end
            S_DONE:     state_next = S_CLEAR;
            default:    state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            total_reg   <= '0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                begin
                    total_reg <= '0;
                    flag_reg  <= 1'b0;
                end
                S_LD_WR2:
                    // self-indexed network reports zero with the flag raised
                    flag_reg <= (source_reg == sink_reg);
                S_AUG_R2:
                begin
                    if (p_reg == src_reg)
                    begin
                        if (tsum > TW'(FLOW_MAX))
                        begin
                            total_reg <= FLOW_MAX;
                            flag_reg  <= 1'b1;
                        end
                        else
                        begin
                            total_reg <= tsum[31:0];
                        end
                    end
                end
                S_DONE: clr_reg <= '0;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                a_reg       <= NW'(from_node);
                b_reg       <= NW'(to_node);
                cap_reg     <= capacity;
                last_reg    <= last_edge;
                edge_ok_reg <= (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);
                n_reg       <= n_eff;
                src_reg     <= NW'(source_reg);
                dst_reg     <= NW'(sink_reg);
            end
            S_LD_WR2: v_reg <= '0;
            S_VIS_CLR: v_reg <= v_reg + 1'b1;
            S_BFS_INIT:
            begin
                head_reg <= '0;
                tail_reg <= (NW+1)'(1);
            end
            S_POP: head_reg <= head_reg + 1'b1;
            S_POP_W: u_reg <= q_rdata;
            S_BN_W:
            begin
                bu_reg <= bn_rdata;
                v_reg  <= '0;
            end
            S_SC_CHK:
            begin
                v_reg <= v_reg + 1'b1;
                if (hit)
                begin
                    tail_reg <= tail_reg + 1'b1;
                    push_reg <= CAP_WIDTH'(alu_y);
                    cur_reg  <= dst_reg;
                end
            end
            S_AUG_PW: p_reg <= par_rdata;
            S_AUG_R2:
            begin
                cur_reg <= p_reg;
                v_reg   <= '0;
            end
            S_DONE:
            begin
                total_flow_reg <= total_reg;
                flow_flag_reg  <= flag_reg;
            end
            default: ;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign total_flow = total_flow_reg;
    assign flow_flag  = flow_flag_reg;

    // a result is followed by the clearing pass, never by another result
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("result strobe repeated");
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_CLEAR)) else $error("result outside clear");
    a_mark_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIS_CLR) |-> (v_reg < n_reg))
        else $error("mark clearing beyond node count");
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC_RD) |-> (head_reg <= tail_reg))
        else $error("queue head passed tail");
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max flow engine
// Streams random undirected networks as edge items, predicts each maximum flow
// with a software Edmonds-Karp on its own residual matrix and checks every
// result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
import mfe_pkg::*;

typedef struct {
    bit [31:0] flow;
    bit        flag;
} flow_result_t;

class flow_scoreboard;
    bit [23:0]    resid [128][128];
    bit [23:0]    bneck [128];
    int           parent [128];
    bit [7:0]     node_count;
    bit [6:0]     src;
    bit [6:0]     snk;
    flow_result_t pending [$];
    int           errors;

    function new();
        node_count = 8'd2;
        src        = 7'd0;
        snk        = 7'd1;
        errors     = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [7:0] data);
        case (idx)
            CFG_NODE_COUNT: node_count = data;
            CFG_SOURCE:     src        = data[6:0];
            CFG_SINK:       snk        = data[6:0];
            default:        ;
        endcase
    endfunction

    function bit [23:0] sat_add(bit [23:0] a, bit [23:0] b);
        bit [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? 24'hFF_FFFF : s[23:0];
    endfunction

    // shortest path by BFS, neighbours in ascending order
    function bit find_path(int n);
        bit seen [128];
        int fifo [128];
        int head;
        int tail;
        int u;
        foreach (seen[i]) seen[i] = 1'b0;
        head = 0;
        tail = 0;
        seen[src] = 1'b1;
        bneck[src] = 24'hFF_FFFF;
        fifo[tail] = int'(src);
        tail = tail + 1;
        while (head < tail) begin
            u = fifo[head];
            head = head + 1;
            for (int v = 0; v < n; v++) begin
                if (!seen[v] && resid[u][v] != 0) begin
                    seen[v]   = 1'b1;
                    parent[v] = u;
                    bneck[v]  = (resid[u][v] < bneck[u]) ? resid[u][v] : bneck[u];
                    if (tail < 128) begin
                        fifo[tail] = v;
                        tail = tail + 1;
                    end
                    if (v == int'(snk))
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function void note_edge(bit [6:0] a, bit [6:0] b, bit [15:0] cap, bit last);
        flow_result_t r;
        bit [63:0]    total;
        bit [23:0]    push;
        int           n;
        int           v;
        int           p;
        resid[a][b] = sat_add(resid[a][b], {8'd0, cap});
        resid[b][a] = sat_add(resid[b][a], {8'd0, cap});
        if (!last)
            return;
        n = (node_count > 8'd128) ? 128 : int'(node_count);
        total = 0;
        r.flag = 1'b0;
        if (src == snk) begin
            r.flag = 1'b1;
        end else if (int'(src) < n && int'(snk) < n) begin
            while (find_path(n)) begin
                push = bneck[snk];
                v = int'(snk);
                while (v != int'(src)) begin
                    p = parent[v];
                    resid[p][v] = resid[p][v] - push;
                    resid[v][p] = sat_add(resid[v][p], push);
                    v = p;
                end
                total = total + 64'(push);
                if (total > 64'hFFFF_FFFF) begin
                    total = 64'hFFFF_FFFF;
                    r.flag = 1'b1;
                    break;
                end
            end
        end
        r.flow = total[31:0];
        pending = {pending, r};
        for (int i = 0; i < 128; i++)
            for (int j = 0; j < 128; j++)
                resid[i][j] = 24'd0;
    endfunction

    function void check_result(bit [31:0] flow, bit flag);
        flow_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result flow=%h flag=%b", $time, flow, flag);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.flow !== flow) begin
            $display("%0t: total_flow expected %h actual %h", $time, e.flow, flow);
            errors++;
        end
        if (e.flag !== flag) begin
            $display("%0t: flow_flag expected %b actual %b", $time, e.flag, flag);
            errors++;
        end
    endfunction
endclass

module tb_top;
    // register index past the end of the list, must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;
    // limit covers the clearing pass after every network plus the searches
    localparam int CYCLE_LIMIT = 20_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [6:0]  from_node = '0;
    logic [6:0]  to_node = '0;
    logic [15:0] capacity = '0;
    logic        last_edge = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        busy;
    logic        done;
    logic [31:0] total_flow;
    logic        flow_flag;

    flow_scoreboard sb = new();
    int  cycles = 0;
    int  edges_sent = 0;
    int  networks = 0;
    bit  no_gaps = 1'b0;

    max_flow_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .from_node  (from_node),
        .to_node    (to_node),
        .capacity   (capacity),
        .last_edge  (last_edge),
        .done       (done),
        .total_flow (total_flow),
        .flow_flag  (flow_flag),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result strobe cannot be stalled: check on every edge it is high
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(total_flow, flow_flag);
    end

    // one edge item; start stays up between back-to-back items
    task automatic send_edge(bit [6:0] a, bit [6:0] b, bit [15:0] cap, bit last);
        int gap;
        start     <= 1'b1;
        from_node <= a;
        to_node   <= b;
        capacity  <= cap;
        last_edge <= last;
        do @(posedge clk); while (busy);
        sb.note_edge(a, b, cap, last);
        edges_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        // the last item must drop start, else the next network leaks in
        if (last || gap > 0)
            start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // registers only change once the previous network is fully answered
    task automatic write_reg(bit [1:0] idx, bit [7:0] data);
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(bit [7:0] n, bit [6:0] s, bit [6:0] t);
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_SOURCE, {1'b0, s});
        write_reg(CFG_SINK, {1'b0, t});
    endtask

    // random network; mostly small and well formed, some odd settings
    task automatic random_network();
        int        sel;
        int        n;
        int        span;
        int        count;
        bit [6:0]  s;
        bit [6:0]  t;
        bit [6:0]  a;
        bit [6:0]  b;
        bit [15:0] cap;
        sel = $urandom_range(0, 19);
        if (sel < 14)      n = $urandom_range(2, 10);
        else if (sel < 16) n = 128;
        else if (sel < 17) n = 255;
        else if (sel < 18) n = $urandom_range(0, 1);
        else               n = $urandom_range(11, 127);
        span = (n > 128) ? 128 : ((n < 2) ? 2 : n);
        sel = $urandom_range(0, 9);
        s = 7'($urandom_range(0, span - 1));
        if (sel == 0)
            t = s;
        else if (sel == 1)
            t = 7'($urandom_range(0, 127));
        else
        begin
            t = 7'($urandom_range(0, span - 1));
            if (t == s)
                t = 7'((int'(s) + 1) % span);
        end
        setup(n[7:0], s, t);
        no_gaps = ($urandom_range(0, 3) == 0);
        count = $urandom_range(1, 14);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                a = 7'($urandom_range(0, 127));
                b = 7'($urandom_range(0, 127));
            end
            else
            begin
                a = 7'($urandom_range(0, span - 1));
                b = 7'($urandom_range(0, span - 1));
            end
            case ($urandom_range(0, 3))
                0: cap = 16'($urandom_range(0, 15));
                1: cap = 16'($urandom);
                2: cap = 16'hFFFF;
                default: cap = 16'd0;
            endcase
            send_edge(a, b, cap, k == count - 1);
        end
        networks++;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: two nodes, single full edge
        send_edge(7'd0, 7'd1, 16'hFFFF, 1'b1);

        // top node as source, self loop, zero capacity, two routes
        setup(8'd128, 7'd127, 7'd0);
        send_edge(7'd127, 7'd64, 16'hFFFF, 1'b0);
        send_edge(7'd64, 7'd0, 16'h1234, 1'b0);
        send_edge(7'd127, 7'd127, 16'hFFFF, 1'b0);
        send_edge(7'd5, 7'd6, 16'd0, 1'b0);
        send_edge(7'd127, 7'd0, 16'd1, 1'b1);

        // source equals sink
        setup(8'd8, 7'd3, 7'd3);
        send_edge(7'd3, 7'd4, 16'd10, 1'b1);

        // sink outside the node count
        setup(8'd4, 7'd0, 7'd9);
        send_edge(7'd0, 7'd9, 16'd100, 1'b1);

        // node count above the maximum acts as the maximum
        setup(8'd255, 7'd0, 7'd100);
        send_edge(7'd0, 7'd100, 16'd77, 1'b1);

        // node count zero: nothing searched; spare index ignored
        write_reg(CFG_NODE_COUNT, 8'd0);
        write_reg(CFG_SOURCE, 8'd0);
        write_reg(CFG_SINK, 8'd1);
        write_reg(CFG_SPARE, 8'hFF);
        send_edge(7'd0, 7'd1, 16'd5, 1'b1);

        // detour through a node beyond the count is never taken
        setup(8'd3, 7'd0, 7'd2);
        send_edge(7'd0, 7'd5, 16'd50, 1'b0);
        send_edge(7'd5, 7'd2, 16'd50, 1'b0);
        send_edge(7'd0, 7'd1, 16'd9, 1'b0);
        send_edge(7'd1, 7'd2, 16'd7, 1'b1);

        // parallel edges pile up past the 24-bit entry limit
        setup(8'd2, 7'd1, 7'd0);
        no_gaps = 1'b1;
        for (int k = 0; k < 260; k++)
            send_edge(7'd0, 7'd1, 16'hFFFF, k == 259);
        no_gaps = 1'b0;

        while (edges_sent < 400 || networks < 12)
            random_network();

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
design/mfe_pkg.sv
design/mfe_ram.sv
design/mfe_alu.sv
design/max_flow_engine.sv
tb/tb_top.sv
